@@ hdl/btpc_pkg.sv @@
// Shared types, constants and helpers for the barometric compensation pipeline.
// No dependencies.
package btpc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned RAW_W  = 16;
    localparam int unsigned NUM_CFG = 5;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PAIR_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_E = 3'd4;

    localparam logic [31:0] B5_OFFSET  = 32'd4000;
    localparam logic [31:0] PRESS_SCALE = 32'd50000;
    localparam logic [31:0] C_X1       = 32'd3038;
    localparam logic [31:0] C_X2       = 32'hFFFF_E343; // -7357
    localparam logic [31:0] C_OFS      = 32'd3791;
    localparam logic [31:0] B4_BIAS    = 32'd32768;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        asr32 = 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        mul32 = 32'(a * b);
    endfunction

endpackage

@@ hdl/baro_temp_pressure_compensation_top.sv @@
// Top level of the barometric temperature and pressure compensation pipeline.
// Depends on btpc_pkg and btpc_udiv.
//
// The block takes one raw temperature and pressure pair per cycle while not
// stalled and returns one compensated result per pair. A result shows on
// out_valid after two 32-stage pipelined dividers (temperature, then pressure)
// and ten register stages around them, the output register included. A stalled
// result in the output register freezes the whole pipeline and stalls the input
// in the same cycle; without output stalls a new pair can enter every cycle.
// The user must write calibration only while idle; the block does not enforce it.
module baro_temp_pressure_compensation_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [btpc_pkg::RAW_W-1:0]          raw_temp,
    input  logic [btpc_pkg::RAW_W-1:0]          raw_press,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [btpc_pkg::WORD_W-1:0]  temp_tenths,
    output logic signed [btpc_pkg::WORD_W-1:0]  press_pa,
    output logic                                div_error,
    input  logic                                cfg_we,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [btpc_pkg::CFG_W-1:0]          cfg_data
);
    import btpc_pkg::*;

    logic [31:0] pair_a_reg, pair_b_reg, pair_c_reg, pair_d_reg, pair_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_a_reg <= '0;
            pair_b_reg <= '0;
            pair_c_reg <= '0;
            pair_d_reg <= '0;
            pair_e_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PAIR_A: pair_a_reg <= cfg_data;
                REG_PAIR_B: pair_b_reg <= cfg_data;
                REG_PAIR_C: pair_c_reg <= cfg_data;
                REG_PAIR_D: pair_d_reg <= cfg_data;
                REG_PAIR_E: pair_e_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(pair_a_reg[31:16]);
    assign ac2 = sx16(pair_a_reg[15:0]);
    assign ac3 = sx16(pair_b_reg[31:16]);
    assign ac4 = {16'd0, pair_b_reg[15:0]};
    assign ac5 = {16'd0, pair_c_reg[31:16]};
    assign ac6 = {16'd0, pair_c_reg[15:0]};
    assign b1  = sx16(pair_d_reg[31:16]);
    assign b2  = sx16(pair_d_reg[15:0]);
    assign mc  = sx16(pair_e_reg[31:16]);
    assign md  = sx16(pair_e_reg[15:0]);

    // Whole pipeline advances unless the output register holds a result
    // that is stalled.
    logic adv;
    logic out_valid_reg;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Stage 1: x1 product.
    logic        s1_vld_reg;
    logic [31:0] s1_prod_reg;
    logic [15:0] s1_up_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_vld_reg <= 1'b0;
        else if (adv) s1_vld_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prod_reg <= mul32({16'd0, raw_temp} - ac6, ac5);
            s1_up_reg   <= raw_press;
        end
    end

    // Stage 2: x1, divisor, signed operands for the temperature divider.
    logic [31:0] t_x1, t_den, t_num;
    assign t_x1  = asr32(s1_prod_reg, 15);
    assign t_den = t_x1 + md;
    assign t_num = mc << 11;

    logic        s2_vld_reg;
    logic [31:0] s2_x1_reg, s2_na_reg, s2_nd_reg;
    logic        s2_neg_reg, s2_zero_reg;
    logic [15:0] s2_up_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s2_vld_reg <= 1'b0;
        else if (adv) s2_vld_reg <= s1_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_x1_reg   <= t_x1;
            s2_na_reg   <= t_num[31] ? 32'd0 - t_num : t_num;
            s2_nd_reg   <= t_den[31] ? 32'd0 - t_den : t_den;
            s2_neg_reg  <= t_num[31] ^ t_den[31];
            s2_zero_reg <= (t_den == 32'd0);
            s2_up_reg   <= s1_up_reg;
        end
    end

    localparam int unsigned TSIDE_W = 32 + 1 + 1 + 16;
    logic              td_vld;
    logic [31:0]       td_q;
    logic [TSIDE_W-1:0] td_side;
    btpc_udiv #(.SIDE_W(TSIDE_W)) u_tdiv (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(s2_vld_reg),
        .num(s2_na_reg), .den(s2_nd_reg),
        .side_in({s2_x1_reg, s2_neg_reg, s2_zero_reg, s2_up_reg}),
        .out_vld(td_vld), .quo(td_q), .side_out(td_side)
    );

    // Stage 3: b5, temperature, b6.
    logic [31:0] t3_x2, t3_b5;
    assign t3_x2 = td_side[17] ? 32'd0 - td_q : td_q;
    assign t3_b5 = td_side[49:18] + t3_x2;

    logic        s3_vld_reg, s3_err_reg;
    logic [31:0] s3_temp_reg, s3_b6_reg;
    logic [15:0] s3_up_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s3_vld_reg <= 1'b0;
        else if (adv) s3_vld_reg <= td_vld;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_err_reg  <= td_side[16];
            s3_temp_reg <= asr32(t3_b5 + 32'd8, 4);
            s3_b6_reg   <= t3_b5 - B5_OFFSET;
            s3_up_reg   <= td_side[15:0];
        end
    end

    // Stage 4: b6 squared, ac2*b6, ac3*b6.
    logic        s4_vld_reg, s4_err_reg;
    logic [31:0] s4_temp_reg, s4_sq_reg, s4_ac2b6_reg, s4_ac3b6_reg;
    logic [15:0] s4_up_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s4_vld_reg <= 1'b0;
        else if (adv) s4_vld_reg <= s3_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_err_reg   <= s3_err_reg;
            s4_temp_reg  <= s3_temp_reg;
            s4_sq_reg    <= mul32(s3_b6_reg, s3_b6_reg);
            s4_ac2b6_reg <= mul32(ac2, s3_b6_reg);
            s4_ac3b6_reg <= mul32(ac3, s3_b6_reg);
            s4_up_reg    <= s3_up_reg;
        end
    end

    // Stage 5: b2*sq and b1*sq.
    logic [31:0] t5_sq;
    assign t5_sq = asr32(s4_sq_reg, 12);
    logic        s5_vld_reg, s5_err_reg;
    logic [31:0] s5_temp_reg, s5_b2sq_reg, s5_b1sq_reg, s5_ac2b6_reg, s5_ac3b6_reg;
    logic [15:0] s5_up_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s5_vld_reg <= 1'b0;
        else if (adv) s5_vld_reg <= s4_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_err_reg   <= s4_err_reg;
            s5_temp_reg  <= s4_temp_reg;
            s5_b2sq_reg  <= mul32(b2, t5_sq);
            s5_b1sq_reg  <= mul32(b1, t5_sq);
            s5_ac2b6_reg <= s4_ac2b6_reg;
            s5_ac3b6_reg <= s4_ac3b6_reg;
            s5_up_reg    <= s4_up_reg;
        end
    end

    // Stage 6: b3 and the b4 factor.
    logic [31:0] t6_x3a, t6_b3n, t6_b3, t6_x3b;
    assign t6_x3a = asr32(s5_b2sq_reg, 11) + asr32(s5_ac2b6_reg, 11);
    assign t6_b3n = (ac1 << 2) + t6_x3a + 32'd2;
    // Signed divide by four truncates toward zero.
    assign t6_b3  = asr32(t6_b3n + (t6_b3n[31] ? 32'd3 : 32'd0), 2);
    assign t6_x3b = asr32(asr32(s5_ac3b6_reg, 13) + asr32(s5_b1sq_reg, 16) + 32'd2, 2);

    logic        s6_vld_reg, s6_err_reg;
    logic [31:0] s6_temp_reg, s6_b3_reg, s6_b4f_reg;
    logic [15:0] s6_up_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s6_vld_reg <= 1'b0;
        else if (adv) s6_vld_reg <= s5_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_err_reg  <= s5_err_reg;
            s6_temp_reg <= s5_temp_reg;
            s6_b3_reg   <= t6_b3;
            s6_b4f_reg  <= t6_x3b + B4_BIAS;
            s6_up_reg   <= s5_up_reg;
        end
    end

    // Stage 7: b4 product and b7 product.
    logic        s7_vld_reg, s7_err_reg;
    logic [31:0] s7_temp_reg, s7_b4p_reg, s7_b7_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s7_vld_reg <= 1'b0;
        else if (adv) s7_vld_reg <= s6_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_err_reg  <= s6_err_reg;
            s7_temp_reg <= s6_temp_reg;
            s7_b4p_reg  <= mul32(ac4, s6_b4f_reg);
            s7_b7_reg   <= mul32({16'd0, s6_up_reg} - s6_b3_reg, PRESS_SCALE);
        end
    end

    logic [31:0] t7_b4, t7_num;
    logic        t7_big;
    assign t7_b4  = s7_b4p_reg >> 15;
    assign t7_big = s7_b7_reg[31];
    assign t7_num = t7_big ? s7_b7_reg : (s7_b7_reg << 1);

    localparam int unsigned PSIDE_W = 32 + 1 + 1;
    logic               pd_vld;
    logic [31:0]        pd_q;
    logic [PSIDE_W-1:0] pd_side;
    logic               pd_err;
    btpc_udiv #(.SIDE_W(PSIDE_W + 1)) u_pdiv (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(s7_vld_reg),
        .num(t7_num), .den(t7_b4),
        .side_in({s7_temp_reg, t7_big, s7_err_reg, (t7_b4 == 32'd0)}),
        .out_vld(pd_vld), .quo(pd_q), .side_out({pd_side, pd_err})
    );

    // Stage 8: p and x1 square.
    logic [31:0] t8_p, t8_x1;
    assign t8_p  = pd_side[1] ? (pd_q << 1) : pd_q;
    assign t8_x1 = asr32(t8_p, 8);
    logic        s8_vld_reg, s8_err_reg;
    logic [31:0] s8_temp_reg, s8_p_reg, s8_sq_reg, s8_x2p_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s8_vld_reg <= 1'b0;
        else if (adv) s8_vld_reg <= pd_vld;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_err_reg  <= pd_side[0] | pd_err;
            s8_temp_reg <= pd_side[33:2];
            s8_p_reg    <= t8_p;
            s8_sq_reg   <= mul32(t8_x1, t8_x1);
            s8_x2p_reg  <= mul32(C_X2, t8_p);
        end
    end

    // Stage 9: times 3038.
    logic        s9_vld_reg, s9_err_reg;
    logic [31:0] s9_temp_reg, s9_p_reg, s9_x1p_reg, s9_x2p_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s9_vld_reg <= 1'b0;
        else if (adv) s9_vld_reg <= s8_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_err_reg  <= s8_err_reg;
            s9_temp_reg <= s8_temp_reg;
            s9_p_reg    <= s8_p_reg;
            s9_x1p_reg  <= mul32(s8_sq_reg, C_X1);
            s9_x2p_reg  <= s8_x2p_reg;
        end
    end

    logic [31:0] t9_p;
    assign t9_p = s9_p_reg
        + asr32(asr32(s9_x1p_reg, 16) + asr32(s9_x2p_reg, 16) + C_OFS, 4);

    // Output register.
    logic [31:0] temp_reg, press_reg;
    logic        err_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (adv) out_valid_reg <= s9_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err_reg   <= s9_err_reg;
            temp_reg  <= s9_err_reg ? 32'd0 : s9_temp_reg;
            press_reg <= s9_err_reg ? 32'd0 : t9_p;
        end
    end

    assign out_valid   = out_valid_reg;
    assign temp_tenths = $signed(temp_reg);
    assign press_pa    = $signed(press_reg);
    assign div_error   = err_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_error) |-> (temp_tenths == 0 && press_pa == 0))
        else $error("error result carries nonzero data");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(press_pa)))
        else $error("stalled result changed");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output stall");
`endif
endmodule

@@ hdl/btpc_udiv.sv @@
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Carries a side payload alongside; uses btpc_pkg.
module btpc_udiv #(
    parameter int unsigned SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_vld,
    input  logic [31:0]       num,
    input  logic [31:0]       den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [31:0]       quo,
    output logic [SIDE_W-1:0] side_out
);
    import btpc_pkg::*;

    localparam int unsigned N = 32;

    logic              vld_reg  [N+1];
    logic [31:0]       rem_reg  [N+1];
    logic [31:0]       q_reg    [N+1];
    logic [31:0]       d_reg    [N+1];
    logic [SIDE_W-1:0] side_reg [N+1];

    always_comb
    begin
        vld_reg[0]  = in_vld;
        rem_reg[0]  = 32'd0;
        q_reg[0]    = num;
        d_reg[0]    = den;
        side_reg[0] = side_in;
    end

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [32:0] shifted;
        logic [32:0] diff;
        always_comb
        begin
            shifted = {rem_reg[s], q_reg[s][31]};
            diff    = shifted - {1'b0, d_reg[s]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!diff[32])
                begin
                    rem_reg[s+1] <= diff[31:0];
                    q_reg[s+1]   <= {q_reg[s][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= shifted[31:0];
                    q_reg[s+1]   <= {q_reg[s][30:0], 1'b0};
                end
                d_reg[s+1]    <= d_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_vld  = vld_reg[N];
    assign quo      = q_reg[N];
    assign side_out = side_reg[N];
endmodule
